[rtl/core/chm_pkg.sv]
// ----------------------------------------------------------------------------
// chm_pkg
// Shared types and constants for the chained hash map.
// ----------------------------------------------------------------------------
package chm_pkg;

   localparam int KEY_W       = 32;
   localparam int VAL_W       = 32;
   localparam int TOTAL_W     = 7;
   localparam int CMD_W       = 2;
   localparam int REQ_DATA_W  = 64;
   localparam int RSP_DATA_W  = 48;
   localparam int DEF_BUCKETS = 64;
   localparam int DEF_ENTRIES = 64;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUT        = 2'd0,
      CMD_PUT_ABSENT = 2'd1,
      CMD_LOOKUP     = 2'd2,
      CMD_REMOVE     = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [KEY_W-1:0]  key;
      logic [VAL_W-1:0]  value;
   } item_type;

   typedef struct packed {
      logic               found;
      logic               changed;
      logic               full_res;
      logic [VAL_W-1:0]   read_value;
      logic [TOTAL_W-1:0] entry_total;
   } result_type;

endpackage

[rtl/core/chained_hash_map.sv]
// ----------------------------------------------------------------------------
// chained_hash_map
// Key-value store with separate chaining over a fixed slot pool.
//
// Requests enter on the req_ stream: tuser carries the command, tdata the key
// and value. Each request yields exactly one word on the rsp_ stream with the
// found, changed and full flags, the old value and the live entry count.
// A classifier computes the bucket (a combinational key mask for a power-of-two
// bucket count, otherwise a registered division by reciprocal multiplication), a two-word
// queue follows, and the engine walks the chain through registered memory
// reads, one chain link at a time; an insert also pops the free stack. The
// engine finishes one request before it takes the next, so the chain walk
// sets the rate.
// After reset the engine sweeps all BUCKETS bucket heads, one per cycle,
// before it takes a request; the queue may fill meanwhile.
// When rsp_tready is low the result word holds and the engine waits; the
// classifier and queue keep accepting until the queue is full.
// ----------------------------------------------------------------------------
module chained_hash_map #(
   parameter int BUCKETS = chm_pkg::DEF_BUCKETS,
   parameter int ENTRIES = chm_pkg::DEF_ENTRIES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [chm_pkg::REQ_DATA_W-1:0]  req_tdata,  // key, value
   input  logic [chm_pkg::CMD_W-1:0]       req_tuser,  // cmd
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [chm_pkg::RSP_DATA_W-1:0]  rsp_tdata   // found, changed, full_res,
                                                       // read_value, entry_total
);
   import chm_pkg::*;

   localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int QW = $bits(item_type) + BW;

   item_type      req_item, f_item, e_item;
   logic [BW-1:0] f_bucket, e_bucket;
   logic          f_valid, f_ready, e_valid, e_ready;
   logic [QW-1:0] q_out;
   result_type    res;

   assign req_item.cmd   = cmd_type'(req_tuser);
   assign req_item.key   = req_tdata[KEY_W-1:0];
   assign req_item.value = req_tdata[KEY_W+VAL_W-1:KEY_W];

   chm_front #(.BUCKETS(BUCKETS), .BW(BW)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_item(req_item),
      .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item),
      .out_bucket(f_bucket)
   );

   chm_queue #(.W(QW)) u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_data({f_bucket, f_item}),
      .out_valid(e_valid), .out_ready(e_ready), .out_data(q_out)
   );

   assign e_item   = q_out[$bits(item_type)-1:0];
   assign e_bucket = q_out[QW-1:$bits(item_type)];

   chm_engine #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES), .BW(BW)) u_engine (
      .clock(clock), .reset(reset),
      .in_valid(e_valid), .in_ready(e_ready), .in_item(e_item),
      .in_bucket(e_bucket),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_result(res)
   );

   assign rsp_tdata = {(RSP_DATA_W - 42)'(0), res.entry_total, res.read_value,
                       res.full_res, res.changed, res.found};

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (res.entry_total <= TOTAL_W'(ENTRIES)))
      else $error("entry count above pool size");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !res.found) |-> (res.read_value == '0))
      else $error("value reported on a miss");

   a_full_excl: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && res.full_res) |-> (!res.found && !res.changed))
      else $error("refused insert reported as hit or change");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && res.full_res) |-> (res.entry_total == TOTAL_W'(ENTRIES)))
      else $error("pool reported full below capacity");

endmodule

[rtl/core/chm_front.sv]
// ----------------------------------------------------------------------------
// chm_front
// Accept a request word and compute its bucket index (key modulo bucket count).
// ----------------------------------------------------------------------------
module chm_front #(
   parameter int BUCKETS = chm_pkg::DEF_BUCKETS,
   parameter int BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  chm_pkg::item_type in_item,
   output logic              out_valid,
   input  logic              out_ready,
   output chm_pkg::item_type out_item,
   output logic [BW-1:0]     out_bucket
);
   import chm_pkg::*;

   generate
      if ((BUCKETS & (BUCKETS - 1)) == 0) begin : g_mask
         assign in_ready   = out_ready;
         assign out_valid  = in_valid;
         assign out_item   = in_item;
         assign out_bucket = BW'(in_item.key & KEY_W'(BUCKETS - 1));
      end else begin : g_serial
         localparam int          L       = $clog2(BUCKETS);
         localparam logic [63:0] MAGIC_W = ((64'd1 << KEY_W) *
                                            ((64'd1 << L) - 64'(BUCKETS))) /
                                           64'(BUCKETS) + 64'd1;
         localparam logic [KEY_W-1:0] MAGIC = KEY_W'(MAGIC_W);

         logic               busy_ff, busy_in;
         logic               done_ff, done_in;
         logic [1:0]         cnt_ff, cnt_in;
         logic [KEY_W-1:0]   t1_ff, t1_in;
         logic [KEY_W-1:0]   q_ff, q_in;
         logic [BW-1:0]      rem_ff, rem_in;
         item_type           item_ff, item_in;
         logic [2*KEY_W-1:0] prod;
         logic [KEY_W-1:0]   diff;
         logic [KEY_W-1:0]   quo;

         assign prod = 64'(item_ff.key) * 64'(MAGIC);
         assign diff = item_ff.key - t1_ff;
         assign quo  = (t1_ff + (diff >> 1)) >> (L - 1);

         always_comb begin
            busy_in = busy_ff;
            done_in = done_ff;
            cnt_in  = cnt_ff;
            t1_in   = t1_ff;
            q_in    = q_ff;
            rem_in  = rem_ff;
            item_in = item_ff;
            if (!busy_ff) begin
               if (in_valid) begin
                  busy_in = 1'b1;
                  item_in = in_item;
                  cnt_in  = '0;
               end
            end else if (!done_ff) begin
               case (cnt_ff)
                  2'd0: begin
                     t1_in = prod[2*KEY_W-1:KEY_W];
                  end
                  2'd1: begin
                     q_in = quo;
                  end
                  default: begin
                     rem_in  = item_ff.key[BW-1:0] -
                               BW'(q_ff[BW-1:0] * BW'(BUCKETS));
                     done_in = 1'b1;
                  end
               endcase
               cnt_in = cnt_ff + 2'd1;
            end else if (out_ready) begin
               busy_in = 1'b0;
               done_in = 1'b0;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b0;
            end else begin
               busy_ff <= busy_in;
               done_ff <= done_in;
            end
            cnt_ff  <= cnt_in;
            t1_ff   <= t1_in;
            q_ff    <= q_in;
            rem_ff  <= rem_in;
            item_ff <= item_in;
         end

         assign in_ready   = !busy_ff;
         assign out_valid  = done_ff;
         assign out_item   = item_ff;
         assign out_bucket = rem_ff;
      end
   endgenerate

endmodule

[rtl/core/chm_queue.sv]
// ----------------------------------------------------------------------------
// chm_queue
// Two-word queue between the classifier and the table engine.
// ----------------------------------------------------------------------------
module chm_queue #(
   parameter int W = chm_pkg::REQ_DATA_W
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  logic [W-1:0] in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output logic [W-1:0] out_data
);
   import chm_pkg::*;

   logic [W-1:0] slot_ff [2];
   logic         wr_ptr_ff, rd_ptr_ff;
   logic [1:0]   cnt_ff;
   logic         push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + 2'd1;
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - 2'd1;
         end
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

[rtl/core/chm_engine.sv]
// ----------------------------------------------------------------------------
// chm_engine
// Walk a bucket chain in the slot pool and carry out put, lookup or remove.
// ----------------------------------------------------------------------------
module chm_engine #(
   parameter int BUCKETS = chm_pkg::DEF_BUCKETS,
   parameter int ENTRIES = chm_pkg::DEF_ENTRIES,
   parameter int BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  chm_pkg::item_type   in_item,
   input  logic [BW-1:0]       in_bucket,
   output logic                out_valid,
   input  logic                out_ready,
   output chm_pkg::result_type out_result
);
   import chm_pkg::*;

   localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_HEAD  = 7'b0000100,
      S_SLOT  = 7'b0001000,
      S_ACT   = 7'b0010000,
      S_INS   = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   logic [EW:0]      head_mem [BUCKETS];
   logic [KEY_W-1:0] key_mem  [ENTRIES];
   logic [VAL_W-1:0] val_mem  [ENTRIES];
   logic [EW:0]      next_mem [ENTRIES];
   logic [EW-1:0]    stk_mem  [ENTRIES];

   state_type        state_ff, state_in;
   item_type         item_ff, item_in;
   logic [BW-1:0]    bkt_ff, bkt_in;
   logic [BW-1:0]    clr_ff, clr_in;
   logic [EW-1:0]    cur_ff, cur_in;
   logic [EW-1:0]    prev_ff, prev_in;
   logic             prev_ok_ff, prev_ok_in;
   logic             low_ff, low_in;
   logic [CW-1:0]    top_ff, top_in;
   logic [CW-1:0]    lw_ff, lw_in;
   logic [CW-1:0]    live_ff, live_in;
   logic             out_valid_ff, out_valid_in;
   result_type       res_ff, res_in;

   logic [EW:0]      hd_q;
   logic [KEY_W-1:0] sk_q;
   logic [VAL_W-1:0] sv_q;
   logic [EW:0]      sn_q;
   logic [EW-1:0]    st_q;

   logic             hd_re, hd_we, sl_re, kv_we, v_we, n_we, st_re, st_we;
   logic [BW-1:0]    hd_ra, hd_wa;
   logic [EW:0]      hd_wd, n_wd;
   logic [EW-1:0]    sl_ra, kv_wa, v_wa, n_wa, st_ra, st_wa, st_wd, new_slot;
   logic [VAL_W-1:0] v_wd;
   logic [CW-1:0]    top_m1;
   logic             out_free, is_insert;

   assign out_free  = !out_valid_ff || out_ready;
   assign in_ready  = (state_ff == S_IDLE) && out_free;
   assign out_valid = out_valid_ff;
   assign out_result = res_ff;
   assign top_m1    = top_ff - CW'(1);
   assign is_insert = (item_ff.cmd == CMD_PUT) || (item_ff.cmd == CMD_PUT_ABSENT);
   assign new_slot  = low_ff ? EW'(top_m1) : st_q;

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      bkt_in       = bkt_ff;
      clr_in       = clr_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      prev_ok_in   = prev_ok_ff;
      low_in       = low_ff;
      top_in       = top_ff;
      lw_in        = lw_ff;
      live_in      = live_ff;
      out_valid_in = out_valid_ff && !out_ready;
      res_in       = res_ff;
      hd_re = 1'b0; hd_ra = in_bucket;
      hd_we = 1'b0; hd_wa = bkt_ff; hd_wd = '0;
      sl_re = 1'b0; sl_ra = hd_q[EW-1:0];
      kv_we = 1'b0; kv_wa = new_slot;
      v_we  = 1'b0; v_wa  = cur_ff; v_wd = item_ff.value;
      n_we  = 1'b0; n_wa  = prev_ff; n_wd = sn_q;
      st_re = 1'b0; st_ra = EW'(top_m1);
      st_we = 1'b0; st_wa = EW'(top_ff); st_wd = cur_ff;

      case (state_ff)
         S_CLEAR: begin
            hd_we = 1'b1;
            hd_wa = clr_ff;
            hd_wd = '0;
            clr_in = clr_ff + BW'(1);
            if (clr_ff == BW'(BUCKETS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (in_valid && out_free) begin
               item_in    = in_item;
               bkt_in     = in_bucket;
               hd_re      = 1'b1;
               prev_ok_in = 1'b0;
               state_in   = S_HEAD;
            end
         end
         S_HEAD: begin
            if (hd_q[EW]) begin
               sl_re    = 1'b1;
               sl_ra    = hd_q[EW-1:0];
               cur_in   = hd_q[EW-1:0];
               state_in = S_SLOT;
            end else begin
               res_in.found = 1'b0;
               state_in     = S_ACT;
            end
         end
         S_SLOT: begin
            if (sk_q == item_ff.key) begin
               res_in.found = 1'b1;
               state_in     = S_ACT;
            end else begin
               prev_in    = cur_ff;
               prev_ok_in = 1'b1;
               if (sn_q[EW]) begin
                  sl_re  = 1'b1;
                  sl_ra  = sn_q[EW-1:0];
                  cur_in = sn_q[EW-1:0];
               end else begin
                  res_in.found = 1'b0;
                  state_in     = S_ACT;
               end
            end
         end
         S_ACT: begin
            res_in.changed    = 1'b0;
            res_in.full_res   = 1'b0;
            res_in.read_value = '0;
            state_in          = S_DONE;
            if (res_ff.found) begin
               res_in.read_value = sv_q;
               if (item_ff.cmd == CMD_PUT) begin
                  v_we = 1'b1;
               end else if (item_ff.cmd == CMD_REMOVE) begin
                  if (prev_ok_ff) begin
                     n_we = 1'b1;
                  end else begin
                     hd_we = 1'b1;
                     hd_wd = sn_q;
                  end
                  if (top_ff < CW'(ENTRIES)) begin
                     st_we  = 1'b1;
                     top_in = top_ff + CW'(1);
                  end
                  if (live_ff != '0) begin
                     live_in = live_ff - CW'(1);
                  end
                  res_in.changed = 1'b1;
               end
            end else if (is_insert) begin
               if (top_ff == '0) begin
                  res_in.full_res = 1'b1;
               end else begin
                  st_re    = 1'b1;
                  low_in   = (top_m1 < lw_ff);
                  state_in = S_INS;
               end
            end
         end
         S_INS: begin
            kv_we = 1'b1;
            v_we  = 1'b1;
            v_wa  = new_slot;
            n_we  = 1'b1;
            n_wa  = new_slot;
            n_wd  = hd_q;
            hd_we = 1'b1;
            hd_wd = {1'b1, new_slot};
            top_in  = top_m1;
            lw_in   = low_ff ? top_m1 : lw_ff;
            live_in = live_ff + CW'(1);
            res_in.changed = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            res_in.entry_total = TOTAL_W'(live_ff);
            out_valid_in       = 1'b1;
            state_in           = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         top_ff       <= CW'(ENTRIES);
         lw_ff        <= CW'(ENTRIES);
         live_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         top_ff       <= top_in;
         lw_ff        <= lw_in;
         live_ff      <= live_in;
         out_valid_ff <= out_valid_in;
      end
      item_ff    <= item_in;
      bkt_ff     <= bkt_in;
      cur_ff     <= cur_in;
      prev_ff    <= prev_in;
      prev_ok_ff <= prev_ok_in;
      low_ff     <= low_in;
      res_ff     <= res_in;
   end

   always_ff @(posedge clock) begin
      if (hd_we) begin
         head_mem[hd_wa] <= hd_wd;
      end
      if (hd_re) begin
         hd_q <= head_mem[hd_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (kv_we) begin
         key_mem[kv_wa] <= item_ff.key;
      end
      if (v_we) begin
         val_mem[v_wa] <= v_wd;
      end
      if (n_we) begin
         next_mem[n_wa] <= n_wd;
      end
      if (sl_re) begin
         sk_q <= key_mem[sl_ra];
         sv_q <= val_mem[sl_ra];
         sn_q <= next_mem[sl_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         stk_mem[st_wa] <= st_wd;
      end
      if (st_re) begin
         st_q <= stk_mem[st_ra];
      end
   end

endmodule

[bench/chained_hash_map_test.sv]
// ----------------------------------------------------------------------------
// chained_hash_map_test
// Self-checking bench for the chained hash map. A predictor keeps its own
// bucket chains, slot pool and free stack, works out the response to every
// accepted request and compares each response word field by field. Requests
// come from directed cases, then random traffic over small key sets that
// collide in a few buckets and fill the pool, with random gaps on both sides
// and one long response hold-off.
// ----------------------------------------------------------------------------
module chained_hash_map_test;
   import chm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NB = DEF_BUCKETS;
   localparam int NE = DEF_ENTRIES;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // key, value
   logic [CMD_W-1:0]      req_tuser = '0;  // cmd
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;       // found, changed, full_res, read_value,
                                           // entry_total

   item_type   pending_reqs[$];
   result_type expected_rsps[$];
   int         failures = 0;
   bit         calm = 1'b0;
   int         hold_cycles = 0;
   bit         hold_armed = 1'b0;
   int         accepted = 0;
   bit         req_tready_seen = 1'b0;

   // predictor state
   logic [5:0]  head_idx[NB];
   bit          head_ok[NB];
   logic [31:0] slot_k[NE];
   logic [31:0] slot_v[NE];
   logic [5:0]  nxt_idx[NE];
   bit          nxt_ok[NE];
   logic [5:0]  free_slots[NE];
   int          free_cnt;
   int          live;

   chained_hash_map u_top (.*);

   always #5 clock = ~clock;

   function automatic result_type predict_access(item_type it);
      result_type r;
      int b, cur, prv, steps, s;
      bit ok, prv_ok, hit;
      r = '0;
      b = it.key % NB;
      ok = head_ok[b];
      cur = head_idx[b];
      prv_ok = 0; prv = 0; hit = 0; steps = 0;
      while (ok && steps < NE) begin
         if (slot_k[cur] == it.key) begin
            hit = 1;
            break;
         end
         prv_ok = 1; prv = cur;
         ok = nxt_ok[cur];
         cur = nxt_idx[cur];
         steps++;
      end
      if (hit) begin
         r.found = 1;
         r.read_value = slot_v[cur];
         if (it.cmd == CMD_PUT) begin
            slot_v[cur] = it.value;
         end else if (it.cmd == CMD_REMOVE) begin
            if (prv_ok) begin
               nxt_idx[prv] = nxt_idx[cur];
               nxt_ok[prv] = nxt_ok[cur];
            end else begin
               head_idx[b] = nxt_idx[cur];
               head_ok[b] = nxt_ok[cur];
            end
            nxt_ok[cur] = 0;
            if (free_cnt < NE) free_slots[free_cnt++] = 6'(cur);
            if (live > 0) live--;
            r.changed = 1;
         end
      end else if (it.cmd == CMD_PUT || it.cmd == CMD_PUT_ABSENT) begin
         if (free_cnt == 0) begin
            r.full_res = 1;
         end else begin
            s = free_slots[--free_cnt];
            slot_k[s] = it.key;
            slot_v[s] = it.value;
            nxt_idx[s] = head_idx[b];
            nxt_ok[s] = head_ok[b];
            head_idx[b] = 6'(s);
            head_ok[b] = 1;
            live++;
            r.changed = 1;
         end
      end
      r.entry_total = live[6:0];
      return r;
   endfunction

   function automatic item_type make_req(cmd_type c, logic [31:0] k, logic [31:0] v);
      item_type it;
      it.cmd = c; it.key = k; it.value = v;
      return it;
   endfunction

   function automatic logic [31:0] pick_key(int pool);
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return {2'($urandom_range(0, 3)), 30'd0} | ($urandom_range(0, 3) * NB);
         default: return ($urandom_range(0, pool - 1) * NB) + $urandom_range(0, 2);
      endcase
   endfunction

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_tready_seen) begin
            if (pending_reqs.size() > 0 && (calm || $urandom_range(0, 99) >= 26)) begin
               item_type it;
               it = pending_reqs.pop_front();
               req_tuser <= it.cmd;
               req_tdata <= {it.value, it.key};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      req_tready_seen <= req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         expected_rsps.push_back(predict_access(item_type'({cmd_type'(req_tuser),
                                                         req_tdata[31:0],
                                                         req_tdata[63:32]})));
         accepted++;
      end
   end

   // receiver ready
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else if (!hold_armed && accepted > 300) begin
         hold_armed <= 1'b1;
         hold_cycles <= 400;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || $urandom_range(0, 99) >= 26;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         result_type got, exp_r;
         got.found       = rsp_tdata[0];
         got.changed     = rsp_tdata[1];
         got.full_res    = rsp_tdata[2];
         got.read_value  = rsp_tdata[34:3];
         got.entry_total = rsp_tdata[41:35];
         if (expected_rsps.size() == 0) begin
            $error("unexpected response word %h", rsp_tdata);
            failures++;
         end else begin
            exp_r = expected_rsps.pop_front();
            if (got.found !== exp_r.found) begin
               $error("found exp %0d got %0d", exp_r.found, got.found); failures++;
            end
            if (got.changed !== exp_r.changed) begin
               $error("changed exp %0d got %0d", exp_r.changed, got.changed); failures++;
            end
            if (got.full_res !== exp_r.full_res) begin
               $error("full_res exp %0d got %0d", exp_r.full_res, got.full_res); failures++;
            end
            if (got.read_value !== exp_r.read_value) begin
               $error("read_value exp %h got %h", exp_r.read_value, got.read_value);
               failures++;
            end
            if (got.entry_total !== exp_r.entry_total) begin
               $error("entry_total exp %0d got %0d", exp_r.entry_total, got.entry_total);
               failures++;
            end
         end
      end
   end

   initial begin
      int n, pool;
      cmd_type c;
      for (int i = 0; i < NB; i++) begin head_ok[i] = 0; head_idx[i] = 0; end
      for (int i = 0; i < NE; i++) begin
         free_slots[i] = 6'(i); nxt_ok[i] = 0; nxt_idx[i] = 0; slot_k[i] = 0;
         slot_v[i] = 0;
      end
      free_cnt = NE;
      live = 0;

      pending_reqs.push_back(make_req(CMD_LOOKUP, 32'd0, 32'd0));
      pending_reqs.push_back(make_req(CMD_REMOVE, 32'hFFFF_FFFF, 32'd0));
      pending_reqs.push_back(make_req(CMD_PUT, 32'd0, 32'h7FFF_FFFF));
      pending_reqs.push_back(make_req(CMD_PUT, 32'hFFFF_FFFF, 32'h8000_0000));
      pending_reqs.push_back(make_req(CMD_PUT, 32'd64, 32'hFFFF_FFFF));
      pending_reqs.push_back(make_req(CMD_PUT, 32'd128, 32'h5555_AAAA));
      pending_reqs.push_back(make_req(CMD_PUT, 32'd64, 32'h0000_0001));
      pending_reqs.push_back(make_req(CMD_PUT_ABSENT, 32'd0, 32'h1234_5678));
      pending_reqs.push_back(make_req(CMD_PUT_ABSENT, 32'd192, 32'hAAAA_5555));
      pending_reqs.push_back(make_req(CMD_LOOKUP, 32'd64, 32'd0));
      pending_reqs.push_back(make_req(CMD_LOOKUP, 32'd256, 32'd0));
      pending_reqs.push_back(make_req(CMD_REMOVE, 32'd64, 32'd0));
      pending_reqs.push_back(make_req(CMD_REMOVE, 32'd192, 32'd0));
      pending_reqs.push_back(make_req(CMD_REMOVE, 32'd0, 32'd0));
      pending_reqs.push_back(make_req(CMD_LOOKUP, 32'd128, 32'd0));
      pending_reqs.push_back(make_req(CMD_REMOVE, 32'd64, 32'd0));
      for (int i = 0; i < 70; i++)
         pending_reqs.push_back(make_req(CMD_PUT_ABSENT, i * 7 + 1000, $urandom()));
      for (int i = 0; i < 70; i++)
         pending_reqs.push_back(make_req(CMD_REMOVE, i * 7 + 1000, 32'd0));

      n = 0;
      while (n < 2000) begin
         pool = ($urandom_range(0, 3) == 0) ? 120 : 24;
         for (int j = 0; j < 100; j++) begin
            c = cmd_type'($urandom_range(0, 3));
            pending_reqs.push_back(make_req(c, pick_key(pool), $urandom()));
            n++;
         end
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      wait (accepted > 1200);
      calm = 1'b1;
      wait (accepted > 1500);
      calm = 1'b0;
      wait (pending_reqs.size() == 0 && !req_tvalid);
      wait (expected_rsps.size() == 0);
      repeat (200) @(posedge clock);
      if (failures == 0 && expected_rsps.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #20ms;
      $display("Regression FAIL");
      $finish;
   end
endmodule

[files.f]
rtl/core/chm_pkg.sv
rtl/core/chm_front.sv
rtl/core/chm_queue.sv
rtl/core/chm_engine.sv
rtl/core/chained_hash_map.sv
bench/chained_hash_map_test.sv
